@@ rtl/tmcw_pkg.sv @@
// Shared types and constants for the text-mode console writer.
// Used by every module of the block but tmcw_ram; depends on nothing.
`default_nettype none

package tmcw_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int TAB_SPACES = 8;

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int COL_W      = $clog2(COLUMNS);
	localparam int ROW_W      = (ROWS > 2) ? $clog2(ROWS) : 1;
	localparam int TAB_W      = $clog2(TAB_SPACES + 1);
	localparam int CELL_W     = 16;

	localparam logic       CMD_PUT     = 1'b0;
	localparam logic       CMD_READ    = 1'b1;
	localparam logic       KIND_CURSOR = 1'b0;
	localparam logic       KIND_CELL   = 1'b1;
	localparam logic [7:0] CH_NEWLINE  = 8'h0A;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] ATTR_RESET  = 8'h07;

	typedef struct packed {
		logic        cmd;
		logic [7:0]  char_code;
		logic [10:0] cell_index;
	} req_item_t;

	typedef struct packed {
		logic        kind;
		logic [10:0] cursor_pos;
		logic [7:0]  cell_char;
		logic [7:0]  cell_attr;
		logic        last;
	} rsp_item_t;

	typedef struct packed {
		logic      load;
		rsp_item_t item;
	} emit_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PUT,
		ST_EMIT,
		ST_SCROLL,
		ST_RD,
		ST_RD_EMIT
	} state_t;

endpackage

`default_nettype wire

@@ rtl/tmcw_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module tmcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/tmcw_outbuf.sv @@
// Result output register: holds one result item until the consumer takes it.
// Depends on tmcw_pkg.
`default_nettype none

module tmcw_outbuf (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tmcw_pkg::emit_t   emit,
	output logic                   free,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output tmcw_pkg::rsp_item_t    rsp
);

	logic                valid_q;
	tmcw_pkg::rsp_item_t item_q;

	assign free      = !valid_q || rsp_ready;
	assign rsp_valid = valid_q;
	assign rsp       = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (emit.load) begin
			valid_q <= 1'b1;
		end else if (rsp_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.load) begin
			item_q <= emit.item;
		end
	end

endmodule

`default_nettype wire

@@ rtl/tmcw_ctrl.sv @@
// Console sequencer: cursor, attribute register, cell writes, reads, and the
// sweep that clears the store after reset and scrolls it. Depends on tmcw_pkg.
`default_nettype none

module tmcw_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_ready,
	input  wire tmcw_pkg::req_item_t           req,
	input  wire logic                          cfg_we,
	input  wire logic [7:0]                    cfg_wdata,
	output tmcw_pkg::emit_t                    emit,
	input  wire logic                          free,
	output logic                               ram_we,
	output logic [tmcw_pkg::ADDR_W-1:0]        ram_waddr,
	output logic [tmcw_pkg::CELL_W-1:0]        ram_wdata,
	output logic                               ram_re,
	output logic [tmcw_pkg::ADDR_W-1:0]        ram_raddr,
	input  wire logic [tmcw_pkg::CELL_W-1:0]   ram_rdata
);

	localparam int AW = tmcw_pkg::ADDR_W;

	tmcw_pkg::state_t    state_q, state_d;
	tmcw_pkg::req_item_t item_q;
	logic [7:0]                   attr_q;
	logic [tmcw_pkg::COL_W-1:0]   col_q;
	logic [tmcw_pkg::ROW_W-1:0]   row_q;
	logic [AW-1:0]                base_q;
	logic [tmcw_pkg::TAB_W-1:0]   tab_cnt_q;
	logic                         emit_after_q;
	logic [AW-1:0]                sweep_q;

	logic          wr_v_s1;
	logic [AW-1:0] wr_addr_s1;
	logic          wr_zero_s1;

	logic          is_newline, is_tab, col_end, row_end, sweep_end, in_range;
	logic [AW-1:0] pos;
	logic [7:0]    put_char;

	assign is_newline = item_q.char_code == tmcw_pkg::CH_NEWLINE;
	assign is_tab     = item_q.char_code == tmcw_pkg::CH_TAB;
	assign col_end    = col_q == tmcw_pkg::COL_W'(tmcw_pkg::COLUMNS - 1);
	assign row_end    = row_q == tmcw_pkg::ROW_W'(tmcw_pkg::ROWS - 1);
	assign sweep_end  = sweep_q == AW'(tmcw_pkg::CELL_COUNT - 1);
	assign in_range   = 32'(item_q.cell_index) < 32'(tmcw_pkg::CELL_COUNT);
	assign pos        = base_q + AW'(col_q);
	assign put_char   = is_tab ? tmcw_pkg::CH_SPACE : item_q.char_code;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tmcw_pkg::ST_CLEAR: begin
				if (sweep_end) state_d = tmcw_pkg::ST_IDLE;
			end
			tmcw_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_d = (req.cmd == tmcw_pkg::CMD_READ) ? tmcw_pkg::ST_RD
					                                          : tmcw_pkg::ST_PUT;
				end
			end
			tmcw_pkg::ST_PUT: begin
				if (is_newline) begin
					state_d = row_end ? tmcw_pkg::ST_SCROLL : tmcw_pkg::ST_IDLE;
				end else if (col_end && row_end) begin
					state_d = tmcw_pkg::ST_SCROLL;
				end else begin
					state_d = tmcw_pkg::ST_EMIT;
				end
			end
			tmcw_pkg::ST_EMIT: begin
				if (free) begin
					state_d = (tab_cnt_q > tmcw_pkg::TAB_W'(1)) ? tmcw_pkg::ST_PUT
					                                          : tmcw_pkg::ST_IDLE;
				end
			end
			tmcw_pkg::ST_SCROLL: begin
				if (sweep_end) begin
					state_d = emit_after_q ? tmcw_pkg::ST_EMIT : tmcw_pkg::ST_IDLE;
				end
			end
			tmcw_pkg::ST_RD: begin
				state_d = tmcw_pkg::ST_RD_EMIT;
			end
			tmcw_pkg::ST_RD_EMIT: begin
				if (free) state_d = tmcw_pkg::ST_IDLE;
			end
			default: state_d = tmcw_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req_ready = 1'b0;
		emit      = '0;
		ram_we    = 1'b0;
		ram_waddr = pos;
		ram_wdata = {attr_q, put_char};
		ram_re    = 1'b0;
		ram_raddr = AW'(item_q.cell_index);
		case (state_q)
			tmcw_pkg::ST_IDLE: begin
				req_ready = 1'b1;
			end
			tmcw_pkg::ST_PUT: begin
				ram_we = !is_newline;
			end
			tmcw_pkg::ST_EMIT: begin
				emit.load            = free;
				emit.item.kind       = tmcw_pkg::KIND_CURSOR;
				emit.item.cursor_pos = 11'(pos);
				emit.item.last       = tab_cnt_q == tmcw_pkg::TAB_W'(1);
			end
			tmcw_pkg::ST_SCROLL: begin
				ram_re    = sweep_q < AW'(tmcw_pkg::CELL_COUNT - tmcw_pkg::COLUMNS);
				ram_raddr = sweep_q + AW'(tmcw_pkg::COLUMNS);
			end
			tmcw_pkg::ST_RD: begin
				ram_re = 1'b1;
			end
			tmcw_pkg::ST_RD_EMIT: begin
				emit.load            = free;
				emit.item.kind       = tmcw_pkg::KIND_CELL;
				emit.item.cursor_pos = 11'(pos);
				emit.item.cell_char  = in_range ? ram_rdata[7:0] : 8'h00;
				emit.item.cell_attr  = in_range ? ram_rdata[15:8] : 8'h00;
				emit.item.last       = 1'b1;
			end
			default: begin
			end
		endcase
		// sweep write stage
		if (wr_v_s1) begin
			ram_we    = 1'b1;
			ram_waddr = wr_addr_s1;
			ram_wdata = wr_zero_s1 ? '0 : ram_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= tmcw_pkg::ST_CLEAR;
			attr_q       <= tmcw_pkg::ATTR_RESET;
			col_q        <= '0;
			row_q        <= '0;
			base_q       <= '0;
			tab_cnt_q    <= '0;
			emit_after_q <= 1'b0;
			sweep_q      <= '0;
			wr_v_s1      <= 1'b0;
		end else begin
			state_q <= state_d;
			wr_v_s1 <= state_q == tmcw_pkg::ST_CLEAR || state_q == tmcw_pkg::ST_SCROLL;
			if (cfg_we) begin
				attr_q <= cfg_wdata;
			end
			if (state_q == tmcw_pkg::ST_CLEAR || state_q == tmcw_pkg::ST_SCROLL) begin
				sweep_q <= sweep_end ? '0 : sweep_q + AW'(1);
			end
			if (state_q == tmcw_pkg::ST_IDLE && req_valid) begin
				tab_cnt_q <= (req.char_code == tmcw_pkg::CH_TAB)
				             ? tmcw_pkg::TAB_W'(tmcw_pkg::TAB_SPACES)
				             : tmcw_pkg::TAB_W'(1);
			end
			if (state_q == tmcw_pkg::ST_EMIT && free) begin
				tab_cnt_q <= tab_cnt_q - tmcw_pkg::TAB_W'(1);
			end
			if (state_q == tmcw_pkg::ST_PUT) begin
				if (is_newline || col_end) begin
					col_q <= '0;
					if (row_end) begin
						emit_after_q <= !is_newline;
					end else begin
						row_q  <= row_q + tmcw_pkg::ROW_W'(1);
						base_q <= base_q + AW'(tmcw_pkg::COLUMNS);
					end
				end else begin
					col_q <= col_q + tmcw_pkg::COL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tmcw_pkg::ST_IDLE && req_valid) begin
			item_q <= req;
		end
		wr_addr_s1 <= sweep_q;
		wr_zero_s1 <= state_q == tmcw_pkg::ST_CLEAR ||
		              sweep_q >= AW'(tmcw_pkg::CELL_COUNT - tmcw_pkg::COLUMNS);
	end

`ifndef ASSERT_OFF
	a_no_write_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_v_s1 && state_q == tmcw_pkg::ST_PUT))
		else $error("sweep write collides with a cell write");

	a_cursor_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		32'(col_q) < 32'(tmcw_pkg::COLUMNS) && 32'(row_q) < 32'(tmcw_pkg::ROWS))
		else $error("cursor out of bounds");

	a_base_tracks_row: assert property (@(posedge clk) disable iff (!arst_n)
		32'(base_q) == 32'(row_q) * 32'(tmcw_pkg::COLUMNS))
		else $error("row base out of step with row");

	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		emit.load && emit.item.last |=> state_q == tmcw_pkg::ST_IDLE)
		else $error("last result did not end the item");
`endif

endmodule

`default_nettype wire

@@ rtl/text_mode_console_writer_unit.sv @@
// Top level of the text-mode console writer: sequencer, cell store RAM and
// result register. Depends on tmcw_pkg, tmcw_ctrl, tmcw_ram, tmcw_outbuf.
//
//  channel | signals                      | payload
//  --------+------------------------------+------------------------------
//  request | req_valid / req_ready        | req (cmd, char_code, cell_index)
//  result  | rsp_valid / rsp_ready        | rsp (kind, cursor_pos, cell, last)
//  config  | cfg_we                       | cfg_wdata (text attribute)
//
// A put passes idle, put, emit; a tab passes idle, then put and emit for each
// space; a newline passes idle, put; a read passes idle, rd, rd_emit. A scroll
// walks the whole store through the RAM port. After reset the store is
// cleared, one cell a cycle, with req_ready low; config writes are taken
// throughout. A stalled result register holds the sequencer at its emit step.
`default_nettype none

module text_mode_console_writer_unit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_ready,
	input  wire tmcw_pkg::req_item_t req,
	output logic                     rsp_valid,
	input  wire logic                rsp_ready,
	output tmcw_pkg::rsp_item_t      rsp,
	input  wire logic                cfg_we,
	input  wire logic [7:0]          cfg_wdata
);

	tmcw_pkg::emit_t                   emit;
	logic                              free;
	logic                              ram_we, ram_re;
	logic [tmcw_pkg::ADDR_W-1:0]       ram_waddr, ram_raddr;
	logic [tmcw_pkg::CELL_W-1:0]       ram_wdata, ram_rdata;

	tmcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.emit      (emit),
		.free      (free),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	tmcw_ram #(
		.WIDTH (tmcw_pkg::CELL_W),
		.DEPTH (tmcw_pkg::CELL_COUNT)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	tmcw_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.emit      (emit),
		.free      (free),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for text_mode_console_writer_unit: directed and random
// character, tab, newline and cell-read items against an in-bench console model.
// Depends on tmcw_pkg and the RTL under rtl/.
`default_nettype none

module tb;
	import tmcw_pkg::*;

	localparam int SETTLE_CYCLES = CELL_COUNT + 64;
	localparam int IDLE_LIMIT    = 8 * CELL_COUNT;
	localparam int PHASE_ITEMS   = 52;
	localparam int CALM_ITEMS    = 40;
	localparam int MAX_REPORTS   = 10;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	req_item_t req = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_item_t rsp;
	logic      cfg_we = 1'b0;
	logic [7:0] cfg_wdata = '0;

	bit          calm = 1'b0;
	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;
	int          stall_left = 0;

	// console model
	logic [15:0]      screen_model [CELL_COUNT];
	logic [COL_W-1:0] cur_col;
	logic [ROW_W-1:0] cur_row;
	logic [7:0]       attr_model;
	rsp_item_t        expected_rsp [$];

	text_mode_console_writer_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic logic [10:0] cursor_lin();
		int p;
		p = int'(cur_row) * COLUMNS + int'(cur_col);
		return 11'(p);
	endfunction

	function automatic void advance_row();
		cur_col = '0;
		if (int'(cur_row) == ROWS - 1) begin
			for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
				screen_model[i] = screen_model[i + COLUMNS];
			for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
				screen_model[i] = '0;
		end else begin
			cur_row = cur_row + ROW_W'(1);
		end
	endfunction

	function automatic void write_cell(input logic [7:0] ch);
		screen_model[cursor_lin()] = {attr_model, ch};
		if (int'(cur_col) == COLUMNS - 1)
			advance_row();
		else
			cur_col = cur_col + COL_W'(1);
	endfunction

	function automatic void predict_console(input req_item_t it);
		rsp_item_t r;
		r = '0;
		if (it.cmd == CMD_READ) begin
			r.kind = KIND_CELL;
			r.cursor_pos = cursor_lin();
			if (int'(it.cell_index) < CELL_COUNT) begin
				r.cell_char = screen_model[it.cell_index][7:0];
				r.cell_attr = screen_model[it.cell_index][15:8];
			end
			r.last = 1'b1;
			expected_rsp.push_back(r);
		end else if (it.char_code == CH_NEWLINE) begin
			advance_row();
		end else if (it.char_code == CH_TAB) begin
			for (int k = 0; k < TAB_SPACES; k++) begin
				write_cell(CH_SPACE);
				r.kind = KIND_CURSOR;
				r.cursor_pos = cursor_lin();
				r.last = (k == TAB_SPACES - 1);
				expected_rsp.push_back(r);
			end
		end else begin
			write_cell(it.char_code);
			r.kind = KIND_CURSOR;
			r.cursor_pos = cursor_lin();
			r.last = 1'b1;
			expected_rsp.push_back(r);
		end
	endfunction

	function automatic req_item_t put_item(input logic [7:0] ch);
		req_item_t it;
		it.cmd = CMD_PUT;
		it.char_code = ch;
		it.cell_index = 11'($urandom_range(0, 2047));
		return it;
	endfunction

	function automatic req_item_t read_item(input int idx);
		req_item_t it;
		it.cmd = CMD_READ;
		it.char_code = 8'($urandom_range(0, 255));
		it.cell_index = 11'(idx);
		return it;
	endfunction

	task automatic send_item(input req_item_t it);
		int gap;
		gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req <= it;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		predict_console(it);
	endtask

	// drop valid, let all results arrive, then cover a trailing newline scroll
	task automatic settle();
		@(negedge clk) req_valid <= 1'b0;
		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_attribute(input logic [7:0] a);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= a;
		@(negedge clk);
		cfg_we <= 1'b0;
		attr_model = a;
	endtask

	task automatic send_random_item();
		int r;
		int c;
		r = $urandom_range(0, 99);
		c = int'(cursor_lin());
		if (r < 4) begin
			// full row of spaces, forces a wrap
			repeat (COLUMNS / TAB_SPACES) send_item(put_item(CH_TAB));
		end else if (r < 16) begin
			send_item(read_item($urandom_range(c > 64 ? c - 64 : 0, c + 8)));
		end else if (r < 24) begin
			send_item(read_item($urandom_range(0, CELL_COUNT - 1)));
		end else if (r < 27) begin
			send_item(read_item($urandom_range(CELL_COUNT, 2047)));
		end else if (r < 42) begin
			send_item(put_item(CH_NEWLINE));
		end else if (r < 50) begin
			send_item(put_item(CH_TAB));
		end else begin
			send_item(put_item(8'($urandom_range(0, 255))));
		end
	endtask

	task automatic test_control_bytes();
		send_item(read_item(0));
		send_item(put_item(8'h00));
		send_item(put_item(8'hFF));
		send_item(put_item(8'h0D));
		send_item(put_item(CH_TAB));
		send_item(read_item(0));
		send_item(read_item(2));
		send_item(read_item(11));
		send_item(read_item(CELL_COUNT - 1));
		send_item(read_item(CELL_COUNT));
		send_item(read_item(2047));
		send_item(put_item(CH_NEWLINE));
		send_item(put_item(8'h7E));
		send_item(read_item(COLUMNS));
		settle();
	endtask

	task automatic test_row_wrap();
		set_attribute(8'hFF);
		repeat (COLUMNS / TAB_SPACES) send_item(put_item(CH_TAB));
		send_item(put_item(8'h55));
		send_item(read_item(2 * COLUMNS - 1));
		send_item(read_item(2 * COLUMNS));
		settle();
	endtask

	task automatic test_random_text();
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					set_attribute(8'h00);
				end
				1: begin
					set_attribute(8'hFF);
				end
				default: begin
					set_attribute(8'($urandom_range(0, 255)));
				end
			endcase
			repeat (PHASE_ITEMS) send_random_item();
			settle();
		end
	endtask

	task automatic test_steady_stream();
		set_attribute(ATTR_RESET);
		calm = 1'b1;
		repeat (CALM_ITEMS) send_random_item();
		settle();
	endtask

	// result checker
	always @(posedge clk) begin
		rsp_item_t exp_item;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result: kind %0d pos %0d char %h attr %h last %0d",
						rsp.kind, rsp.cursor_pos, rsp.cell_char, rsp.cell_attr, rsp.last);
			end else begin
				exp_item = expected_rsp.pop_front();
				if (rsp !== exp_item) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("mismatch k/p/c/a/l exp %0d/%0d/%h/%h/%0d got %0d/%0d/%h/%h/%0d",
							exp_item.kind, exp_item.cursor_pos, exp_item.cell_char,
							exp_item.cell_attr, exp_item.last,
							rsp.kind, rsp.cursor_pos, rsp.cell_char, rsp.cell_attr,
							rsp.last);
				end
			end
		end
	end

	// result-side backpressure
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp_ready <= 1'b0;
		end else if (arst_n && !calm && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 3);
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= arst_n;
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		for (int i = 0; i < CELL_COUNT; i++)
			screen_model[i] = '0;
		cur_col = '0;
		cur_row = '0;
		attr_model = ATTR_RESET;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		test_control_bytes();
		test_row_wrap();
		test_random_text();
		test_steady_stream();

		if (mismatches == 0 && expected_rsp.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire
